FILE: rtl/core/smad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smad_pkg;

    localparam int WINDOW      = 10;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W       = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 1);
    localparam int DIV_AVG     = WINDOW * 10;
    localparam int DIV_SPD     = 100;
    localparam int DEN_MAX     = (DIV_AVG > DIV_SPD) ? DIV_AVG : DIV_SPD;
    localparam int DEN_W       = $clog2(DEN_MAX + 1);
    localparam int FRAC_W      = 16;
    localparam int MAG_W       = FRAC_W + 1;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 14;
    localparam int PROD_W      = MAG_W + GAIN_W;
    localparam int TMAG_W      = PROD_W - GAIN_FRAC;
    localparam int TURN_W      = 18;
    localparam int SPEED_W     = 7;
    localparam int DZ_W        = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // reciprocals for n * 2^16 / den with n < den: exact when 2^RCP_SH >= den^2
    localparam int     RCP_SH  = 2 * $clog2(DEN_MAX);
    localparam longint RCP_AVG = ((longint'(1) << (FRAC_W + RCP_SH)) + longint'(DIV_AVG) - 1)
                                 / longint'(DIV_AVG);
    localparam longint RCP_SPD = ((longint'(1) << (FRAC_W + RCP_SH)) + longint'(DIV_SPD) - 1)
                                 / longint'(DIV_SPD);
    localparam longint RCP_MAX = (RCP_AVG > RCP_SPD) ? RCP_AVG : RCP_SPD;
    localparam int     RCP_W   = $clog2(RCP_MAX + 1);
    localparam int     QPROD_W = DEN_W + RCP_W;

    localparam logic [MAG_W-1:0]  ONE_Q16  = MAG_W'(1 << FRAC_W);
    localparam logic [SPEED_W-1:0] RST_SPEED    = SPEED_W'(100);
    localparam logic [DZ_W-1:0]    RST_DZ_POS   = DZ_W'(3277);
    localparam logic [DZ_W-1:0]    RST_DZ_NEG   = DZ_W'(5243);
    localparam logic [GAIN_W-1:0]  RST_GAIN_POS = GAIN_W'(27853);
    localparam logic [GAIN_W-1:0]  RST_GAIN_NEG = GAIN_W'(21299);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED    = 3'd0,
        CFG_DZ_POS   = 3'd1,
        CFG_DZ_NEG   = 3'd2,
        CFG_GAIN_POS = 3'd3,
        CFG_GAIN_NEG = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_AVG_START,
        S_AVG_WAIT,
        S_SPD_START,
        S_SPD_WAIT,
        S_MUL,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/steering_moving_average_deadzone_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   valid     stall     payload
// input     i_valid   o_stall   i_curve_sample (16b signed)
// output    o_valid   i_stall   o_turn_command (18b signed Q.16)
// config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// An item passes through idle to take it, a sum over the WINDOW entries of the ring,
// two reciprocal divisions on the shared unit, a multiply and the load.
// o_stall stays high until the result sits in the output register.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous; it clears the ring and the write index and loads the config registers' reset values.

module steering_moving_average_deadzone_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [smad_pkg::SAMPLE_W-1:0]  i_curve_sample,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [smad_pkg::TURN_W-1:0]         o_turn_command,
    input  wire logic                                  i_cfg_we,
    input  wire logic [smad_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [smad_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import smad_pkg::*;

    t_state r_state, n_state;

    t_sample             r_ring [WINDOW];
    logic [IDX_W-1:0]    r_wr;
    logic [IDX_W-1:0]    r_idx;
    logic signed [SUM_W-1:0] r_acc;
    logic                r_neg;
    logic [MAG_W-1:0]    r_avg;
    logic [MAG_W-1:0]    r_bound;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    logic signed [TURN_W-1:0] r_turn;

    logic [SPEED_W-1:0]  r_speed;
    logic [DZ_W-1:0]     r_dz_pos;
    logic [DZ_W-1:0]     r_dz_neg;
    logic [GAIN_W-1:0]   r_gain_pos;
    logic [GAIN_W-1:0]   r_gain_neg;

    logic                div_start;
    logic [SUM_W-1:0]    div_num;
    logic                div_spd;
    logic                div_done;
    logic [MAG_W-1:0]    div_quot;

    logic                in_take;
    logic                out_free;
    logic [SUM_W-1:0]    acc_mag;
    logic [MAG_W-1:0]    eff;
    logic                pos;
    logic [MAG_W-1:0]    dz_mag;
    logic [MAG_W-1:0]    mul_a;
    logic [GAIN_W-1:0]   mul_g;
    logic [TMAG_W-1:0]   tmag;
    logic signed [TURN_W-1:0] turn_val;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign acc_mag  = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);

    smad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_spd   (div_spd),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = acc_mag;
        div_spd   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_idx == IDX_W'(WINDOW - 1)) begin
                    n_state = S_AVG_START;
                end
            end
            S_AVG_START: begin
                div_start = 1'b1;
                n_state   = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (div_done) begin
                    n_state = S_SPD_START;
                end
            end
            S_SPD_START: begin
                div_start = 1'b1;
                div_num   = SUM_W'(r_speed);
                div_spd   = 1'b1;
                n_state   = S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ring and write index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
        end else if (in_take) begin
            r_ring[r_wr] <= i_curve_sample;
            r_wr <= (r_wr == IDX_W'(WINDOW - 1)) ? '0 : r_wr + 1'b1;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= RST_SPEED;
            r_dz_pos   <= RST_DZ_POS;
            r_dz_neg   <= RST_DZ_NEG;
            r_gain_pos <= RST_GAIN_POS;
            r_gain_neg <= RST_GAIN_NEG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED:    r_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_DZ_POS:   r_dz_pos   <= i_cfg_data[DZ_W-1:0];
                CFG_DZ_NEG:   r_dz_neg   <= i_cfg_data[DZ_W-1:0];
                CFG_GAIN_POS: r_gain_pos <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_NEG: r_gain_neg <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp, dead zone, gain select
    always_comb begin
        eff    = (r_avg < r_bound) ? r_avg : r_bound;
        pos    = !r_neg && (eff != '0);
        mul_g  = pos ? r_gain_pos : r_gain_neg;
        dz_mag = pos ? r_dz_pos : r_dz_neg;
        mul_a  = (eff < dz_mag) ? '0 : eff;
    end

    // truncate toward zero and saturate to 18 bits
    always_comb begin
        tmag = r_prod[PROD_W-1:GAIN_FRAC];
        if (r_neg) begin
            if (tmag >= TMAG_W'(1 << (TURN_W - 1))) begin
                turn_val = {1'b1, {(TURN_W-1){1'b0}}};
            end else begin
                turn_val = -$signed(tmag[TURN_W-1:0]);
            end
        end else begin
            if (tmag > TMAG_W'((1 << (TURN_W - 1)) - 1)) begin
                turn_val = {1'b0, {(TURN_W-1){1'b1}}};
            end else begin
                turn_val = $signed(tmag[TURN_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_acc <= '0;
                r_idx <= '0;
            end
            S_SUM: begin
                r_acc <= r_acc + SUM_W'(r_ring[r_idx]);
                r_idx <= r_idx + 1'b1;
            end
            S_AVG_START: begin
                r_neg <= r_acc[SUM_W-1];
            end
            S_AVG_WAIT: begin
                if (div_done) begin
                    r_avg <= div_quot;
                end
            end
            S_SPD_WAIT: begin
                if (div_done) begin
                    r_bound <= div_quot;
                end
            end
            S_MUL: begin
                r_prod <= PROD_W'(mul_a) * PROD_W'(mul_g);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_turn <= turn_val;
        end
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_valid        = r_out_valid;
    assign o_turn_command = r_turn;

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("item accepted but input not stalled next cycle");

    a_div_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_AVG_WAIT || r_state == S_SPD_WAIT))
        else $error("divider finished outside a wait state");

    a_avg_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_avg <= ONE_Q16 && r_bound <= ONE_Q16))
        else $error("average or bound above 1.0");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/smad_div.sv
`timescale 1ns / 1ps
`default_nettype none

module smad_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_spd,
    input  wire logic [smad_pkg::SUM_W-1:0]  i_num,
    output logic                             o_done,
    output logic [smad_pkg::MAG_W-1:0]       o_quot
);
    import smad_pkg::*;

    logic [QPROD_W-1:0] r_prod;
    logic               r_done;
    logic               r_sat;

    logic [SUM_W-1:0]   den;
    logic [RCP_W-1:0]   rcp;

    // n * 2^16 / den as (n * rcp) >> RCP_SH, saturated to 1.0; result registered in the cycle after start
    always_comb begin
        den = i_spd ? SUM_W'(DIV_SPD) : SUM_W'(DIV_AVG);
        rcp = i_spd ? RCP_W'(RCP_SPD) : RCP_W'(RCP_AVG);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= i_num >= den;
            r_prod <= QPROD_W'(i_num[DEN_W-1:0]) * QPROD_W'(rcp);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? ONE_Q16 : {1'b0, r_prod[RCP_SH +: FRAC_W]};

endmodule

`default_nettype wire

FILE: dv/smad_turn_tracker_pkg.sv
`timescale 1ns / 1ps

package smad_turn_tracker_pkg;
    import smad_pkg::*;

    localparam longint UNITY_Q16 = 65536;
    localparam longint GAIN_UNITY = 16384;
    localparam longint TURN_HI = 131071;
    localparam longint TURN_LO = -131072;

    class turn_command_tracker;
        t_sample                  ring [WINDOW];
        int unsigned              wr_pos;
        logic [SPEED_W-1:0]       speed;
        logic [DZ_W-1:0]          dz_pos;
        logic [DZ_W-1:0]          dz_neg;
        logic [GAIN_W-1:0]        gain_pos;
        logic [GAIN_W-1:0]        gain_neg;
        logic signed [TURN_W-1:0] expected_turns [$];
        int                       errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_pos   = 0;
            speed    = RST_SPEED;
            dz_pos   = RST_DZ_POS;
            dz_neg   = RST_DZ_NEG;
            gain_pos = RST_GAIN_POS;
            gain_neg = RST_GAIN_NEG;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED:    speed    = data[SPEED_W-1:0];
                CFG_DZ_POS:   dz_pos   = data[DZ_W-1:0];
                CFG_DZ_NEG:   dz_neg   = data[DZ_W-1:0];
                CFG_GAIN_POS: gain_pos = data[GAIN_W-1:0];
                CFG_GAIN_NEG: gain_neg = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            longint sum;
            longint avg;
            longint bound;
            longint gain;
            longint turn;
            ring[wr_pos] = s;
            wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
            sum = 0;
            foreach (ring[i]) sum += ring[i];
            avg = (sum * UNITY_Q16) / (WINDOW * 10);
            if (avg > UNITY_Q16) avg = UNITY_Q16;
            if (avg < -UNITY_Q16) avg = -UNITY_Q16;
            bound = (longint'(speed) * UNITY_Q16) / 100;
            if (avg > bound) avg = bound;
            if (avg < -bound) avg = -bound;
            if (avg > 0) begin
                gain = longint'(gain_pos);
                if (avg < longint'(dz_pos)) avg = 0;
            end else begin
                gain = longint'(gain_neg);
                if (avg > -longint'(dz_neg)) avg = 0;
            end
            turn = (avg * gain) / GAIN_UNITY;
            if (turn > TURN_HI) turn = TURN_HI;
            if (turn < TURN_LO) turn = TURN_LO;
            expected_turns.push_back(turn[TURN_W-1:0]);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_turn(logic signed [TURN_W-1:0] got);
            logic signed [TURN_W-1:0] want;
            if (expected_turns.size() == 0) begin
                report($sformatf("turn_command %0d with no item pending", got));
            end else begin
                want = expected_turns.pop_front();
                if (got !== want) begin
                    report($sformatf("turn_command %0d, expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return expected_turns.size();
        endfunction
    endclass

endpackage

FILE: dv/steering_moving_average_deadzone_core_test.sv
`timescale 1ns / 1ps

module steering_moving_average_deadzone_core_test;
    import smad_pkg::*;
    import smad_turn_tracker_pkg::*;

    localparam int ITEM_CYCLES  = WINDOW + 7;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 75;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int CFG_NUM_REGS = 5;
    localparam int CFG_IDX_TOP  = (1 << CFG_IDX_W) - 1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    t_sample                  i_curve_sample = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [TURN_W-1:0] o_turn_command;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int quiet_cycles = 0;

    turn_command_tracker turns = new();

    steering_moving_average_deadzone_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_curve_sample (i_curve_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_turn_command (o_turn_command),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            turns.check_turn(o_turn_command);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < 200 && $urandom_range(99) < tx_idle_pct) n++;
        return n;
    endfunction

    function automatic t_sample pick_sample(input int level);
        int r;
        r = $urandom_range(99);
        if (r < 40) return t_sample'(level + int'($urandom_range(10)) - 5);
        if (r < 65) return t_sample'(int'($urandom_range(40)) - 20);
        if (r < 80) return t_sample'(int'($urandom_range(800)) - 400);
        return t_sample'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 60) return CFG_DATA_W'($urandom_range(8000));
        if (r < 80) return CFG_DATA_W'($urandom_range(70000, 60000));
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        turns.set_reg(idx, data);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] spd,
                                input logic [CFG_DATA_W-1:0] dzp,
                                input logic [CFG_DATA_W-1:0] dzn,
                                input logic [CFG_DATA_W-1:0] gp,
                                input logic [CFG_DATA_W-1:0] gn);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_DZ_POS, dzp);
        write_reg(CFG_DZ_NEG, dzn);
        write_reg(CFG_GAIN_POS, gp);
        write_reg(CFG_GAIN_NEG, gn);
        // unmapped index, must be ignored
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_NUM_REGS)),
                  CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input t_sample s, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_curve_sample <= s;
        do @(posedge i_clk); while (o_stall);
        turns.note_sample(s);
    endtask

    task automatic wait_drained(input int settle);
        while (turns.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        t_sample    near_zone [$];
        t_idle_mode mode;
        int         level;

        near_zone = '{t_sample'(0), t_sample'(5), t_sample'(1), t_sample'(-14),
                      t_sample'(-1)};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: dead zone edges on both sides, then full scale
        foreach (near_zone[k]) send_item(near_zone[k], 0);
        repeat (4) send_item(16'sh7fff, 0);
        i_valid <= 1'b0;
        wait_drained(4);

        // open positive side, closed negative side, maximum gains
        apply_config('1, '0, '1, '1, '1);
        repeat (2) send_item(16'sh7fff, 0);
        repeat (3) send_item(-16'sh8000, 0);
        i_valid <= 1'b0;
        wait_drained(4);

        // zero speed bound, then negative saturation
        apply_config('0, '0, '0, '1, '1);
        send_item(16'sh0001, 0);
        send_item(-16'sh0001, 0);
        i_valid <= 1'b0;
        wait_drained(4);
        apply_config(CFG_DATA_W'(100), '0, '0, '1, '1);
        repeat (6) send_item(-16'sh8000, 0);
        i_valid <= 1'b0;
        wait_drained(4);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_config(CFG_DATA_W'(RST_SPEED), CFG_DATA_W'(RST_DZ_POS),
                                CFG_DATA_W'(RST_DZ_NEG), CFG_DATA_W'(RST_GAIN_POS),
                                CFG_DATA_W'(RST_GAIN_NEG));
                1: apply_config('0, '0, '0, '1, '1);
                2: apply_config(CFG_DATA_W'(127), '1, '1, CFG_DATA_W'(16384),
                                CFG_DATA_W'(16384));
                3: apply_config(CFG_DATA_W'(100), CFG_DATA_W'(65536), CFG_DATA_W'(65536),
                                '0, '0);
                4: apply_config('1, '0, '0, '1, '1);
                default: apply_config(CFG_DATA_W'($urandom), pick_threshold(),
                                      pick_threshold(), CFG_DATA_W'($urandom),
                                      CFG_DATA_W'($urandom));
            endcase

            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_NONE: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 0;
                end
                IDLE_SENDER: begin
                    tx_idle_pct  <= 80;
                    rx_stall_pct <= 0;
                end
                IDLE_RECEIVER: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 80;
                end
                default: begin
                    tx_idle_pct  <= 15;
                    rx_stall_pct <= 15;
                end
            endcase
            level = int'($urandom_range(40)) - 20;

            // long receiver hold-off while items keep coming
            if (p == 5) hold_req <= hold_req + 1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == PHASE_ITEMS / 2) begin
                    i_valid <= 1'b0;
                    wait_drained(1);
                end
                if ($urandom_range(99) < 5) level = int'($urandom_range(40)) - 20;
                send_item(pick_sample(level), idle_gap());
            end
            i_valid <= 1'b0;
            wait_drained(4);
        end

        wait_drained(2 * ITEM_CYCLES);
        if (turns.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
